// ----- hdl/ctseq_pkg.sv -----
// ----------------------------------------------------------------------------
// ctseq_pkg
// Shared sizes, codes and the controller command type for the countdown
// task sequencer.
// ----------------------------------------------------------------------------
package ctseq_pkg;

    // Table size, including the fixed init entry at index 0.
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;

    // One table entry in memory: {action, duration, start}.
    localparam int ENTRY_W   = 1 + DUR_W + TIME_W;

    // Item modes.
    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_RESET = 3'd2;
    localparam logic [2:0] MODE_SET   = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    // Add result codes.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_ORDER = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    // Sequencer states.
    localparam logic [1:0] RS_NOT_RUN = 2'd0;
    localparam logic [1:0] RS_RUNNING = 2'd1;
    localparam logic [1:0] RS_HOLD    = 2'd2;
    localparam logic [1:0] RS_DONE    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take the input word and start the table read
        logic commit;   // update the sequencer state and load the result
    } ctseq_cmd_t;

endpackage

// ----- hdl/ctseq_ram.sv -----
// ----------------------------------------------------------------------------
// ctseq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ctseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ----- hdl/ctseq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ctseq_ctrl
// Controller: sequences each word through capture and commit, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module ctseq_ctrl
    import ctseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output ctseq_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    // The result slot can be loaded when it is empty or being taken now.
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/ctseq_dp.sv -----
// ----------------------------------------------------------------------------
// ctseq_dp
// Datapath: task table, sequencer state, countdown arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module ctseq_dp
    import ctseq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctseq_cmd_t               cmd,
    input  logic                     cfg_we,
    input  logic signed [TIME_W-1:0] cfg_data,
    input  logic [2:0]               mode,
    input  logic [TIME_W-1:0]        now_ms,
    input  logic signed [TIME_W-1:0] task_start,
    input  logic [DUR_W-1:0]         task_duration,
    input  logic                     has_action,
    input  logic [1:0]               new_state,
    output logic [1:0]               error_code,
    output logic                     already_running,
    output logic                     fire,
    output logic [IDX_W-1:0]         fire_index,
    output logic                     done_now,
    output logic [1:0]               run_state
);

    // Control state.
    logic [TIME_W-1:0] cfg_reg;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [IDX_W-1:0]  cur_reg,    cur_next;
    logic [1:0]        seq_reg,    seq_next;
    logic [TIME_W-1:0] stamp_reg,  stamp_next;

    // Captured word.
    logic [2:0]        mode_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] tstart_reg;
    logic [DUR_W-1:0]  tdur_reg;
    logic              tact_reg;
    logic [1:0]        nstate_reg;
    logic [TIME_W-1:0] cd_reg;
    logic [IDX_W-1:0]  idx_reg;

    // Result register.
    logic [1:0]        err_reg,   err_next;
    logic              already_reg, already_next;
    logic              fire_reg,  fire_next;
    logic [IDX_W-1:0]  fidx_reg,  fidx_next;
    logic              done_reg,  done_next;

    // Table memory.
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;

    // Decoded entry.
    logic [TIME_W-1:0] ent_start;
    logic [DUR_W-1:0]  ent_len;
    logic              ent_act;
    logic [TIME_W-1:0] diff;
    logic              diff_pos;
    logic              diff_ge_len;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  cur_ext;

    assign count_m1 = count_reg - CNT_W'(1);
    assign cur_ext  = CNT_W'(cur_reg);
    assign rd_addr  = (mode == MODE_ADD) ? count_m1[IDX_W-1:0] : cur_reg;

    ctseq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.capture),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign wr_data = {tact_reg, tdur_reg, tstart_reg};

    // Entry 0 is the init task: start from the register, no duration, always
    // has an action.
    always_comb
    begin
        if (idx_reg == '0)
        begin
            ent_start = cfg_reg;
            ent_len   = '0;
            ent_act   = 1'b1;
        end
        else
        begin
            ent_start = rd_data[TIME_W-1:0];
            ent_len   = rd_data[TIME_W+DUR_W-1:TIME_W];
            ent_act   = rd_data[ENTRY_W-1];
        end
    end

    assign diff        = cd_reg - ent_start;
    assign diff_pos    = !diff[TIME_W-1] && (diff != '0);
    assign diff_ge_len = !diff[TIME_W-1] && (diff >= TIME_W'(ent_len));

    always_comb
    begin
        count_next   = count_reg;
        cur_next     = cur_reg;
        seq_next     = seq_reg;
        stamp_next   = stamp_reg;
        err_next     = ERR_OK;
        already_next = 1'b0;
        fire_next    = 1'b0;
        fidx_next    = '0;
        done_next    = 1'b0;
        wr_en        = 1'b0;
        if (cmd.commit)
        begin
            case (mode_reg)
                MODE_ADD:
                begin
                    if ($signed(ent_start) >= $signed(tstart_reg))
                    begin
                        err_next = ERR_ORDER;
                    end
                    else if (count_reg >= CNT_W'(MAX_TASKS))
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_START:
                begin
                    if (seq_reg == RS_NOT_RUN)
                    begin
                        seq_next   = RS_RUNNING;
                        stamp_next = now_reg;
                    end
                    else
                    begin
                        already_next = 1'b1;
                    end
                end
                MODE_RESET:
                begin
                    seq_next   = RS_NOT_RUN;
                    stamp_next = '0;
                    cur_next   = '0;
                end
                MODE_SET:
                begin
                    seq_next = nstate_reg;
                end
                MODE_TICK:
                begin
                    if (seq_reg == RS_RUNNING && cur_ext < count_reg && diff_pos)
                    begin
                        if (ent_act)
                        begin
                            fire_next = 1'b1;
                            fidx_next = cur_reg;
                        end
                        if (diff_ge_len)
                        begin
                            if (cur_ext + CNT_W'(1) >= count_reg)
                            begin
                                seq_next  = RS_DONE;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                cur_next = cur_reg + IDX_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            count_reg <= CNT_W'(1);
            cur_reg   <= '0;
            seq_reg   <= RS_NOT_RUN;
            stamp_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            count_reg <= count_next;
            cur_reg   <= cur_next;
            seq_reg   <= seq_next;
            stamp_reg <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            now_reg    <= now_ms;
            tstart_reg <= task_start;
            tdur_reg   <= task_duration;
            tact_reg   <= has_action;
            nstate_reg <= new_state;
            idx_reg    <= rd_addr;
            cd_reg     <= now_ms - stamp_reg + cfg_reg;
        end
        if (cmd.commit)
        begin
            err_reg     <= err_next;
            already_reg <= already_next;
            fire_reg    <= fire_next;
            fidx_reg    <= fidx_next;
            done_reg    <= done_next;
        end
    end

    assign error_code      = err_reg;
    assign already_running = already_reg;
    assign fire            = fire_reg;
    assign fire_index      = fidx_reg;
    assign done_now        = done_reg;
    // The state after the item is the live sequencer state while the result
    // is held, as nothing else changes it until the next word commits.
    assign run_state       = seq_reg;

endmodule

// ----- hdl/countdown_task_sequencer.sv -----
// ----------------------------------------------------------------------------
// countdown_task_sequencer
// Timed countdown sequencer: an ordered task table stepped by tick words.
// ----------------------------------------------------------------------------
// Usage. Input words (mode, now_ms and the task fields) arrive on the
// in_valid/in_stall channel; one result word per input leaves on the
// out_valid/out_stall channel. A word moves at a clock edge where valid is
// high and stall is low.
// The countdown_start register is written on the cfg channel, whose ready is
// always high; it should only be written while the block is idle.
// out_valid rises after acceptance: the accepting edge captures the word and
// starts the registered table read, and the commit edge, once the output
// slot is free, evaluates and loads the result. One word is handled at a
// time: the next input word is not accepted until the previous one commits.
// If the receiver stalls, the result is held steady in the output register
// and the next input word can still be captured; its commit then waits
// until the held result is taken.
// Reset clears the sequencer to not-yet-run with only the init entry in the
// table and countdown_start at zero. The table memory itself is not cleared;
// entries are only used once they have been written.
// ----------------------------------------------------------------------------
module countdown_task_sequencer
    import ctseq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [TIME_W-1:0] cfg_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               mode,
    input  logic [TIME_W-1:0]        now_ms,
    input  logic signed [TIME_W-1:0] task_start,
    input  logic [DUR_W-1:0]         task_duration,
    input  logic                     has_action,
    input  logic [1:0]               new_state,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               error_code,
    output logic                     already_running,
    output logic                     fire,
    output logic [IDX_W-1:0]         fire_index,
    output logic                     done_now,
    output logic [1:0]               run_state
);

    ctseq_cmd_t cmd;

    // The configuration register can always take a write.
    assign cfg_ready = 1'b1;

    // The controller paces each word and owns the output valid flag.
    ctseq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath holds the table, the sequencer state and the result word.
    ctseq_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .now_ms          (now_ms),
        .task_start      (task_start),
        .task_duration   (task_duration),
        .has_action      (has_action),
        .new_state       (new_state),
        .error_code      (error_code),
        .already_running (already_running),
        .fire            (fire),
        .fire_index      (fire_index),
        .done_now        (done_now),
        .run_state       (run_state)
    );

endmodule
